// ----- rtl/core/csc_pkg.sv -----
// csc_pkg: shared constants, types and mode codes for the color space converter.
// No dependencies; imported by every module of the converter.
package csc_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS     = 12;
  localparam int HUE_FRAC_BITS = 4;
  localparam int COMP_W        = 13;

  typedef logic [COMP_W-1:0] comp_t;

  localparam comp_t ONE      = comp_t'(1 << FRAC_BITS);
  localparam comp_t HUE_FULL = comp_t'(360 << HUE_FRAC_BITS);
  localparam comp_t HUE_MAX  = comp_t'((360 << HUE_FRAC_BITS) - 1);

  // One 60 degree sector is 15 << SECTOR_POW
  localparam int SECTOR_POW = 2 + HUE_FRAC_BITS;
  localparam int SECTOR_W   = 10;
  localparam logic [SECTOR_W-1:0] SECTOR = SECTOR_W'(60 << HUE_FRAC_BITS);

  // Mode codes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_RGB2HSV = 2'd0;
  localparam mode_t MODE_RGB2HSL = 2'd1;
  localparam mode_t MODE_HSV2RGB = 2'd2;
  localparam mode_t MODE_HSL2RGB = 2'd3;

  // Pipelined divider: 25-bit dividend, 13-bit divisor, 13-bit quotient
  localparam int DIV_NUM_W = 25;
  localparam int DIV_DEN_W = 13;
  localparam int DIV_Q_W   = 13;
  localparam int DIV_STEPS = DIV_Q_W;

  // Latencies of both paths, counted from the input register
  localparam int HSX_LAT  = 2 + DIV_STEPS;
  localparam int RGB_CORE = 4;
  localparam int RGB_PAD  = HSX_LAT - RGB_CORE;

  // To-RGB scaling: divide by 2*ONE*SECTOR = 2^PRE_SHIFT * 15
  localparam int PRE_SHIFT   = FRAC_BITS + 1 + SECTOR_POW;
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(((1 << RECIP_SHIFT) + 14) / 15);

  typedef struct packed {
    comp_t a;
    comp_t b;
    comp_t c;
  } color_t;

  typedef struct packed {
    logic valid;
    logic to_rgb;
  } ctl_t;

endpackage

// ----- rtl/core/csc_divider.sv -----
// csc_divider: fully pipelined restoring divider, one quotient bit per stage.
// Depends on csc_pkg. Dividend must be below divisor * 2^DIV_Q_W.
module csc_divider (
  input  logic                           clk,
  input  logic                           en,
  input  logic [csc_pkg::DIV_NUM_W-1:0]  num,
  input  logic [csc_pkg::DIV_DEN_W-1:0]  den,
  output logic [csc_pkg::DIV_Q_W-1:0]    quo
);
  import csc_pkg::*;

  logic [DIV_DEN_W-1:0] rem_in  [DIV_STEPS];
  logic [DIV_Q_W-1:0]   lo_in   [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_in  [DIV_STEPS];
  logic [DIV_DEN_W:0]   trial   [DIV_STEPS];
  logic                 qbit    [DIV_STEPS];
  logic [DIV_DEN_W-1:0] rem_nxt [DIV_STEPS];
  logic [DIV_DEN_W-1:0] rem_r   [DIV_STEPS];
  logic [DIV_Q_W-1:0]   lo_r    [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_r   [DIV_STEPS];

  // Stage inputs: first from the ports, the rest from the previous stage
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    if (g == 0) begin : g_first
      assign rem_in[g] = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
      assign lo_in[g]  = num[DIV_Q_W-1:0];
      assign den_in[g] = den;
    end else begin : g_rest
      assign rem_in[g] = rem_r[g-1];
      assign lo_in[g]  = lo_r[g-1];
      assign den_in[g] = den_r[g-1];
    end

    // Shift in one dividend bit, subtract when it fits
    always_comb begin
      trial[g] = {rem_in[g], lo_in[g][DIV_Q_W-1]};
      qbit[g]  = (trial[g] >= {1'b0, den_in[g]});
      if (qbit[g]) begin
        rem_nxt[g] = DIV_DEN_W'(trial[g] - {1'b0, den_in[g]});
      end else begin
        rem_nxt[g] = trial[g][DIV_DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt[g];
        lo_r[g]  <= {lo_in[g][DIV_Q_W-2:0], qbit[g]};
        den_r[g] <= den_in[g];
      end
    end
  end

  assign quo = lo_r[DIV_STEPS-1];

endmodule

// ----- rtl/core/csc_to_hsx.sv -----
// csc_to_hsx: RGB to HSV / HSL path: extremes, numerators, two pipelined dividers.
// Depends on csc_pkg and csc_divider.
module csc_to_hsx (
  input  logic            clk,
  input  logic            en,
  input  logic            hsl,
  input  csc_pkg::comp_t  red,
  input  csc_pkg::comp_t  green,
  input  csc_pkg::comp_t  blue,
  output csc_pkg::color_t res
);
  import csc_pkg::*;

  typedef struct packed {
    logic  hue_zero;
    logic  sat_zero;
    comp_t third;
  } side_t;

  comp_t              rr, mx, mn, d;
  logic signed [16:0] rs, gs, bs, ds, x_s;
  logic        [13:0] sum;

  logic [14:0] xp_r;
  comp_t       d_r, mx_r, mn_r;
  logic [13:0] sum_r;
  logic        hsl_r;

  logic [DIV_NUM_W-1:0] hue_num_nxt, sat_num_nxt, hue_num_r, sat_num_r;
  comp_t                sat_den_nxt, hue_den_r, sat_den_r;
  side_t                side_nxt;
  side_t                side_r [DIV_STEPS+1];
  logic [DIV_Q_W-1:0]   hue_q, sat_q;

  // Stage 1: max, min, chroma and the wrapped hue numerator in units of d
  always_comb begin
    rr = (red > ONE) ? ONE : red;
    mx = rr;
    mn = rr;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    rs  = $signed({4'b0, rr});
    gs  = $signed({4'b0, green});
    bs  = $signed({4'b0, blue});
    ds  = $signed({4'b0, d});
    if (rr == mx) begin
      x_s = gs - bs;
    end else if (green == mx) begin
      x_s = (ds <<< 1) + bs - rs;
    end else begin
      x_s = (ds <<< 2) + rs - gs;
    end
    if (x_s < 0) x_s = x_s + (ds <<< 2) + (ds <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r  <= x_s[14:0];
      d_r   <= d;
      mx_r  <= mx;
      mn_r  <= mn;
      sum_r <= sum;
      hsl_r <= hsl;
    end
  end

  // Stage 2: dividends, divisors and zero cases
  always_comb begin
    hue_num_nxt = DIV_NUM_W'(xp_r) * DIV_NUM_W'(SECTOR);
    sat_num_nxt = DIV_NUM_W'(d_r) << FRAC_BITS;
    if (!hsl_r) begin
      sat_den_nxt       = mx_r;
      side_nxt.sat_zero = (mx_r == '0);
      side_nxt.third    = mx_r;
    end else begin
      if (sum_r >= {1'b0, ONE}) begin
        sat_den_nxt = COMP_W'({ONE, 1'b0} - sum_r);
      end else begin
        sat_den_nxt = sum_r[COMP_W-1:0];
      end
      side_nxt.sat_zero = (mx_r == '0) || (mn_r == ONE);
      side_nxt.third    = sum_r[COMP_W:1];
    end
    side_nxt.hue_zero = (d_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_num_r <= hue_num_nxt;
      hue_den_r <= d_r;
      sat_num_r <= sat_num_nxt;
      sat_den_r <= sat_den_nxt;
      side_r[0] <= side_nxt;
      for (int i = 1; i <= DIV_STEPS; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  csc_divider u_hue_div (
    .clk (clk),
    .en  (en),
    .num (hue_num_r),
    .den (hue_den_r),
    .quo (hue_q)
  );

  csc_divider u_sat_div (
    .clk (clk),
    .en  (en),
    .num (sat_num_r),
    .den (sat_den_r),
    .quo (sat_q)
  );

  // Zero cases and saturation
  always_comb begin
    if (side_r[DIV_STEPS].hue_zero) begin
      res.a = '0;
    end else begin
      res.a = (hue_q > HUE_MAX) ? HUE_MAX : hue_q;
    end
    if (side_r[DIV_STEPS].sat_zero) begin
      res.b = '0;
    end else begin
      res.b = (sat_q > ONE) ? ONE : sat_q;
    end
    res.c = (side_r[DIV_STEPS].third > ONE) ? ONE : side_r[DIV_STEPS].third;
  end

endmodule

// ----- rtl/core/csc_to_rgb.sv -----
// csc_to_rgb: HSV / HSL to RGB path: chroma, sector, products, scaling by reciprocal.
// Depends on csc_pkg. Padded with a delay line to line up with the other path.
module csc_to_rgb (
  input  logic            clk,
  input  logic            en,
  input  logic            hsl,
  input  csc_pkg::comp_t  hue,
  input  csc_pkg::comp_t  sat,
  input  csc_pkg::comp_t  lum,
  output csc_pkg::color_t res
);
  import csc_pkg::*;

  localparam int CQ_W  = 26;
  localparam int PR_W  = 36;
  localparam int SUM_W = PR_W + 1;
  localparam int X_W   = SUM_W - PRE_SHIFT;
  localparam int Y_W   = X_W + RECIP_W;

  comp_t         h, f;
  logic [13:0]   two_l;
  logic [2:0]    k;
  logic [12:0]   base;
  logic [SECTOR_W-1:0] t;

  logic [CQ_W-2:0]     p_r;
  comp_t               q_r;
  logic                hsl_r;
  logic [2:0]          k1_r, k2_r;
  logic [SECTOR_W-1:0] t_r;

  logic [CQ_W-1:0] cq, mq;
  logic [PR_W-1:0] cf_nxt, xf_nxt, mf_nxt, cf_r, xf_r, mf_r;

  logic [SUM_W-1:0] cm, xm, mm, rf, gf, bf;
  logic [X_W-1:0]   x_r [3];
  logic [Y_W-1:0]   y_r [3];
  color_t           core_res;
  color_t           pad_r [RGB_PAD];

  // Stage 1: chroma factor product, hue sector and offset
  always_comb begin
    h     = (hue > HUE_FULL) ? HUE_FULL : hue;
    two_l = {lum, 1'b0};
    if (!hsl) begin
      f = lum;
    end else if (two_l > {1'b0, ONE}) begin
      f = COMP_W'({ONE, 1'b0} - two_l);
    end else begin
      f = two_l[COMP_W-1:0];
    end
    k = 3'(h > COMP_W'(SECTOR)) + 3'(h > COMP_W'(2 * SECTOR))
      + 3'(h > COMP_W'(3 * SECTOR)) + 3'(h > COMP_W'(4 * SECTOR))
      + 3'(h > COMP_W'(5 * SECTOR));
    base = 13'(k) * 13'(SECTOR);
    if (k[0] == 1'b0) begin
      t = SECTOR_W'(h - base);
    end else begin
      t = SECTOR_W'(base + 13'(SECTOR) - h);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= (CQ_W-1)'(f) * (CQ_W-1)'(sat);
      q_r   <= lum;
      hsl_r <= hsl;
      k1_r  <= k;
      t_r   <= t;
    end
  end

  // Stage 2: chroma and offset (scaled by 2*ONE), times sector width
  always_comb begin
    cq = {p_r, 1'b0};
    if (hsl_r) begin
      mq = {q_r, 13'b0} - CQ_W'(p_r);
    end else begin
      mq = {q_r, 13'b0} - cq;
    end
    cf_nxt = PR_W'(cq) * PR_W'(SECTOR);
    xf_nxt = PR_W'(cq) * PR_W'(t_r);
    mf_nxt = PR_W'(mq) * PR_W'(SECTOR);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cf_r <= cf_nxt;
      xf_r <= xf_nxt;
      mf_r <= mf_nxt;
      k2_r <= k1_r;
    end
  end

  // Stage 3: per-sector component select, drop the power-of-two factor
  always_comb begin
    cm = SUM_W'(cf_r) + SUM_W'(mf_r);
    xm = SUM_W'(xf_r) + SUM_W'(mf_r);
    mm = SUM_W'(mf_r);
    case (k2_r)
      3'd0: begin
        rf = cm; gf = xm; bf = mm;
      end
      3'd1: begin
        rf = xm; gf = cm; bf = mm;
      end
      3'd2: begin
        rf = mm; gf = cm; bf = xm;
      end
      3'd3: begin
        rf = mm; gf = xm; bf = cm;
      end
      3'd4: begin
        rf = xm; gf = mm; bf = cm;
      end
      default: begin
        rf = cm; gf = mm; bf = xm;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= rf[SUM_W-1:PRE_SHIFT];
      x_r[1] <= gf[SUM_W-1:PRE_SHIFT];
      x_r[2] <= bf[SUM_W-1:PRE_SHIFT];
    end
  end

  // Stage 4: divide by 15 through the reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        y_r[i] <= Y_W'(x_r[i]) * Y_W'(RECIP_MUL);
      end
    end
  end

  function automatic comp_t scale_sat(input logic [Y_W-1:0] y);
    logic [Y_W-RECIP_SHIFT-1:0] v;
    v = y[Y_W-1:RECIP_SHIFT];
    return (v > (Y_W-RECIP_SHIFT)'(ONE)) ? ONE : COMP_W'(v);
  endfunction

  assign core_res.a = scale_sat(y_r[0]);
  assign core_res.b = scale_sat(y_r[1]);
  assign core_res.c = scale_sat(y_r[2]);

  // Delay to match the divider path
  always_ff @(posedge clk) begin
    if (en) begin
      pad_r[0] <= core_res;
      for (int i = 1; i < RGB_PAD; i++) begin
        pad_r[i] <= pad_r[i-1];
      end
    end
  end

  assign res = pad_r[RGB_PAD-1];

endmodule

// ----- rtl/core/color_space_converter.sv -----
// color_space_converter: top level; input register, both conversion paths, output register.
// Depends on csc_pkg, csc_to_hsx, csc_to_rgb.
//
// Converts one color per clock between RGB and HSV or HSL, as chosen by in_mode
// with each request. The input register captures a request at the edge that accepts
// it; the request then passes the two setup stages, the 13 stages of the radix-2
// dividers that form hue and saturation, and the output register, which raises
// out_valid. The HSV/HSL to RGB path is shorter and is padded to the same depth,
// so results leave in order.
// The pipeline advances as a whole; while a result waits under out_stall every
// stage holds and in_stall is raised.
module color_space_converter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  csc_pkg::mode_t  in_mode,
  input  csc_pkg::comp_t  in_comp_a,
  input  csc_pkg::comp_t  in_comp_b,
  input  csc_pkg::comp_t  in_comp_c,
  output logic            out_valid,
  input  logic            out_stall,
  output csc_pkg::comp_t  out_a,
  output csc_pkg::comp_t  out_b,
  output csc_pkg::comp_t  out_c
);
  import csc_pkg::*;

  logic   en;
  ctl_t   ctl_nxt;
  ctl_t   ctl_r [HSX_LAT+1];
  comp_t  a_r, b_r, c_r;
  logic   hsl_r;
  color_t hsx_res, rgb_res;
  logic   out_valid_r;
  color_t out_r;

  // Whole pipeline moves unless a result is held at the output
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign ctl_nxt.valid  = in_valid;
  assign ctl_nxt.to_rgb = in_mode inside {MODE_HSV2RGB, MODE_HSL2RGB};

  // Valid and direction travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= HSX_LAT; i++) begin
        ctl_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl_r[0] <= ctl_nxt;
      for (int i = 1; i <= HSX_LAT; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
      out_valid_r <= ctl_r[HSX_LAT].valid;
    end
  end

  // Input register; components b and c (saturation and value or lightness, or green and blue) clamp to 1.0
  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= in_comp_a;
      b_r   <= (in_comp_b > ONE) ? ONE : in_comp_b;
      c_r   <= (in_comp_c > ONE) ? ONE : in_comp_c;
      hsl_r <= in_mode inside {MODE_RGB2HSL, MODE_HSL2RGB};
    end
  end

  csc_to_hsx u_to_hsx (
    .clk   (clk),
    .en    (en),
    .hsl   (hsl_r),
    .red   (a_r),
    .green (b_r),
    .blue  (c_r),
    .res   (hsx_res)
  );

  csc_to_rgb u_to_rgb (
    .clk (clk),
    .en  (en),
    .hsl (hsl_r),
    .hue (a_r),
    .sat (b_r),
    .lum (c_r),
    .res (rgb_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= ctl_r[HSX_LAT].to_rgb ? rgb_res : hsx_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_a     = out_r.a;
  assign out_b     = out_r.b;
  assign out_c     = out_r.c;

endmodule
